[sv/dhtsr_pkg.sv]
package dhtsr_pkg;

  localparam int unsigned ENTRIES   = 256;
  localparam int unsigned ID_SPACE  = 1024;
  localparam int unsigned PAYLOAD_W = 64;

  localparam int unsigned POS_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned ID_W     = $clog2(ID_SPACE);
  localparam int unsigned IDC_W    = $clog2(ID_SPACE + 1);
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned HANDLE_W = 10;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NPOS_W   = 8;
  localparam int unsigned LIVE_W   = 9;

  localparam int unsigned IN_FIELDS_W  = HANDLE_W + DATA_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + HANDLE_W + NPOS_W + DATA_W + 1
                                         + HANDLE_W + LIVE_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned O_STATUS_LSB = 0;
  localparam int unsigned O_NEWH_LSB   = O_STATUS_LSB + STATUS_W;
  localparam int unsigned O_POS_LSB    = O_NEWH_LSB + HANDLE_W;
  localparam int unsigned O_DOUT_LSB   = O_POS_LSB + NPOS_W;
  localparam int unsigned O_MOVED_LSB  = O_DOUT_LSB + DATA_W;
  localparam int unsigned O_MOVH_LSB   = O_MOVED_LSB + 1;
  localparam int unsigned O_LIVE_LSB   = O_MOVH_LSB + HANDLE_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_WRITE  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK
  } state_e;

  typedef struct packed {
    logic             map_en;
    logic [ID_W-1:0]  map_addr;
    logic             ent_en;
    logic [POS_W-1:0] pos_addr;
    logic [POS_W-1:0] last_addr;
  } rd_req_t;

  typedef struct packed {
    logic [POS_W-1:0]     map_pos;
    logic [ID_W-1:0]      own_pos;
    logic [ID_W-1:0]      own_last;
    logic [PAYLOAD_W-1:0] pay_pos;
    logic [PAYLOAD_W-1:0] pay_last;
  } rd_rsp_t;

  typedef struct packed {
    logic                 pay_we;
    logic [POS_W-1:0]     pay_addr;
    logic [PAYLOAD_W-1:0] pay_data;
    logic                 own_we;
    logic [POS_W-1:0]     own_addr;
    logic [ID_W-1:0]      own_data;
    logic                 map_we;
    logic [ID_W-1:0]      map_addr;
    logic [POS_W-1:0]     map_data;
  } wr_req_t;

endpackage

[sv/dhtsr_mem.sv]
module dhtsr_mem (
  input  logic              clk_i,
  input  dhtsr_pkg::rd_req_t rd_req_i,
  input  dhtsr_pkg::wr_req_t wr_req_i,
  output dhtsr_pkg::rd_rsp_t rd_rsp_o
);
  import dhtsr_pkg::*;

  logic [PAYLOAD_W-1:0] pay_mem [ENTRIES];
  logic [ID_W-1:0]      own_mem [ENTRIES];
  logic [POS_W-1:0]     map_mem [ID_SPACE];

  logic [POS_W-1:0]     map_pos_q;
  logic [ID_W-1:0]      own_pos_q;
  logic [ID_W-1:0]      own_last_q;
  logic [PAYLOAD_W-1:0] pay_pos_q;
  logic [PAYLOAD_W-1:0] pay_last_q;

  // id to position map
  always_ff @(posedge clk_i) begin
    if (wr_req_i.map_we) begin
      map_mem[wr_req_i.map_addr] <= wr_req_i.map_data;
    end
    if (rd_req_i.map_en) begin
      map_pos_q <= map_mem[rd_req_i.map_addr];
    end
  end

  // position to id map, two read ports
  always_ff @(posedge clk_i) begin
    if (wr_req_i.own_we) begin
      own_mem[wr_req_i.own_addr] <= wr_req_i.own_data;
    end
    if (rd_req_i.ent_en) begin
      own_pos_q  <= own_mem[rd_req_i.pos_addr];
      own_last_q <= own_mem[rd_req_i.last_addr];
    end
  end

  // dense payload array, two read ports
  always_ff @(posedge clk_i) begin
    if (wr_req_i.pay_we) begin
      pay_mem[wr_req_i.pay_addr] <= wr_req_i.pay_data;
    end
    if (rd_req_i.ent_en) begin
      pay_pos_q  <= pay_mem[rd_req_i.pos_addr];
      pay_last_q <= pay_mem[rd_req_i.last_addr];
    end
  end

  always_comb begin
    rd_rsp_o.map_pos  = map_pos_q;
    rd_rsp_o.own_pos  = own_pos_q;
    rd_rsp_o.own_last = own_last_q;
    rd_rsp_o.pay_pos  = pay_pos_q;
    rd_rsp_o.pay_last = pay_last_q;
  end

endmodule

[sv/dense_handle_table_swap_remove_unit.sv]
// channel   dir  tdata (lsb first)                                           tuser
// s_axis    in   handle[9:0], payload[73:10], zero pad to 80                 kind[1:0]
// m_axis    out  status, new_handle, position, data_out, moved,
//                moved_handle, live_count (104 bits)                         -
//
// every beat runs through an id map read, an entry and last-entry read, then a
// check and write back into the three memories
// one beat in flight at a time; a new beat is taken while the result waits
// a result stalled on m_axis holds the write-back until the output frees
// reset clears the counters, state and output valid only; liveness comes from the id
// counter, the entry count and the position-to-id map, so no clearing pass is run
module dense_handle_table_swap_remove_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dhtsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // handle, payload
  input  logic [dhtsr_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, new_handle, position, data_out, moved, moved_handle, live_count
  output logic [dhtsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import dhtsr_pkg::*;

  state_e state_q, state_d;

  kind_e                kind_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [PAYLOAD_W-1:0] data_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDC_W-1:0]     idc_q, idc_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_q;

  rd_req_t rd_req;
  rd_rsp_t rd_rsp;
  wr_req_t wr_req;

  logic                 s_acc;
  logic                 commit;
  logic                 out_free;
  logic                 live;
  logic [POS_W-1:0]     last_pos;
  status_e              st;
  logic [HANDLE_W-1:0]  new_h;
  logic [NPOS_W-1:0]    pos_r;
  logic [DATA_W-1:0]    dout;
  logic                 mv;
  logic [HANDLE_W-1:0]  mv_h;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign last_pos = POS_W'(count_q - CNT_W'(1));

  dhtsr_mem u_mem (
    .clk_i    (clk_i),
    .rd_req_i (rd_req),
    .wr_req_i (wr_req),
    .rd_rsp_o (rd_rsp)
  );

  always_comb begin
    rd_req.map_en    = s_acc;
    rd_req.map_addr  = ID_W'(s_axis_tdata[HANDLE_W-1:0]);
    rd_req.ent_en    = (state_q == S_LOOKUP);
    rd_req.pos_addr  = rd_rsp.map_pos;
    rd_req.last_addr = last_pos;
  end

  assign live = (IDC_W'(handle_q) < idc_q)
             && (CNT_W'(rd_rsp.map_pos) < count_q)
             && (rd_rsp.own_pos == ID_W'(handle_q));

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    st      = ST_OK;
    new_h   = '0;
    pos_r   = '0;
    dout    = '0;
    mv      = 1'b0;
    mv_h    = '0;
    count_d = count_q;
    idc_d   = idc_q;
    wr_req  = '0;
    case (kind_q)
      KIND_ADD: begin
        if (idc_q >= IDC_W'(ID_SPACE)) begin
          st = ST_EXHAUSTED;
        end else if (count_q >= CNT_W'(ENTRIES)) begin
          st = ST_FULL;
        end else begin
          new_h           = HANDLE_W'(idc_q[ID_W-1:0]);
          pos_r           = NPOS_W'(count_q[POS_W-1:0]);
          count_d         = count_q + CNT_W'(1);
          idc_d           = idc_q + IDC_W'(1);
          wr_req.pay_we   = commit;
          wr_req.pay_addr = count_q[POS_W-1:0];
          wr_req.pay_data = data_q;
          wr_req.own_we   = commit;
          wr_req.own_addr = count_q[POS_W-1:0];
          wr_req.own_data = idc_q[ID_W-1:0];
          wr_req.map_we   = commit;
          wr_req.map_addr = idc_q[ID_W-1:0];
          wr_req.map_data = count_q[POS_W-1:0];
        end
      end
      default: begin
        if (!live) begin
          st = ST_UNKNOWN;
        end else begin
          pos_r = NPOS_W'(rd_rsp.map_pos);
          dout  = DATA_W'(rd_rsp.pay_pos);
          if (kind_q == KIND_REMOVE) begin
            count_d = count_q - CNT_W'(1);
            if (rd_rsp.map_pos < last_pos) begin
              mv              = 1'b1;
              mv_h            = HANDLE_W'(rd_rsp.own_last);
              wr_req.pay_we   = commit;
              wr_req.pay_addr = rd_rsp.map_pos;
              wr_req.pay_data = rd_rsp.pay_last;
              wr_req.own_we   = commit;
              wr_req.own_addr = rd_rsp.map_pos;
              wr_req.own_data = rd_rsp.own_last;
              wr_req.map_we   = commit;
              wr_req.map_addr = rd_rsp.own_last;
              wr_req.map_data = rd_rsp.map_pos;
            end
          end else if (kind_q == KIND_WRITE) begin
            wr_req.pay_we   = commit;
            wr_req.pay_addr = rd_rsp.map_pos;
            wr_req.pay_data = data_q;
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        count_q <= count_d;
        idc_q   <= idc_d;
      end
    end
  end

  // beat fields and result payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q   <= kind_e'(s_axis_tuser);
      handle_q <= s_axis_tdata[HANDLE_W-1:0];
      data_q   <= s_axis_tdata[HANDLE_W +: PAYLOAD_W];
    end
    if (commit) begin
      out_q <= OUT_TDATA_W'({LIVE_W'(count_d), mv_h, mv, dout, pos_r, new_h, st});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

[sv/dhtsr_checker.sv]
module dhtsr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tvalid_i,
  input logic                               s_tready_i,
  input logic                               m_tvalid_i,
  input logic                               m_tready_i,
  input logic [dhtsr_pkg::OUT_TDATA_W-1:0]  m_tdata_i
);
  import dhtsr_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] new_h;
  logic [NPOS_W-1:0]   pos;
  logic [DATA_W-1:0]   dout;
  logic                moved;
  logic [LIVE_W-1:0]   live_cnt;

  assign status   = m_tdata_i[O_STATUS_LSB +: STATUS_W];
  assign new_h    = m_tdata_i[O_NEWH_LSB +: HANDLE_W];
  assign pos      = m_tdata_i[O_POS_LSB +: NPOS_W];
  assign dout     = m_tdata_i[O_DOUT_LSB +: DATA_W];
  assign moved    = m_tdata_i[O_MOVED_LSB];
  assign live_cnt = m_tdata_i[O_LIVE_LSB +: LIVE_W];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled result beat changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("second beat taken while one is in flight");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (status != ST_OK) |-> !moved && (dout == '0) && (new_h == '0))
    else $error("failed item carries result data");

  a_moved_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && moved |-> (status == ST_OK) && (LIVE_W'(pos) < live_cnt))
    else $error("relocation outside the packed range");

endmodule

bind dense_handle_table_swap_remove_unit dhtsr_checker u_dhtsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dhtsr_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    status_e                status;
    logic [HANDLE_W-1:0]    new_handle;
    logic [NPOS_W-1:0]      position;
    logic [DATA_W-1:0]      data_out;
    logic                   moved;
    logic [HANDLE_W-1:0]    moved_handle;
    logic [LIVE_W-1:0]      live_count;
  } table_result_t;

  class handle_table_tracker;
    logic [DATA_W-1:0]   payload_at [ENTRIES];
    logic [HANDLE_W-1:0] owner_at [ENTRIES];
    logic [NPOS_W-1:0]   slot_of_id [ID_SPACE];
    bit                  id_live [ID_SPACE];
    int unsigned         count;
    int unsigned         id_next;
    table_result_t       awaited_results [$];
    status_e             last_status = ST_OK;
    int unsigned         n_errors;

    function logic [HANDLE_W-1:0] pick_live_id();
      return owner_at[$urandom_range(0, count - 1)];
    endfunction

    function void apply_request(kind_e kind, logic [HANDLE_W-1:0] handle,
                                logic [DATA_W-1:0] payload);
      table_result_t r;
      int unsigned   p;
      int unsigned   last;
      r.status       = ST_OK;
      r.new_handle   = '0;
      r.position     = '0;
      r.data_out     = '0;
      r.moved        = 1'b0;
      r.moved_handle = '0;
      if (kind == KIND_ADD) begin
        if (id_next >= ID_SPACE) begin
          r.status = ST_EXHAUSTED;
        end else if (count >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          p = count;
          payload_at[p] = payload;
          owner_at[p] = HANDLE_W'(id_next);
          slot_of_id[id_next] = NPOS_W'(p);
          id_live[id_next] = 1'b1;
          r.new_handle = HANDLE_W'(id_next);
          r.position = NPOS_W'(p);
          id_next++;
          count++;
        end
      end else if (!id_live[handle]) begin
        r.status = ST_UNKNOWN;
      end else begin
        p = 32'(slot_of_id[handle]);
        r.position = NPOS_W'(p);
        r.data_out = payload_at[p];
        if (kind == KIND_REMOVE) begin
          id_live[handle] = 1'b0;
          count--;
          last = count;
          if (p < last) begin
            payload_at[p] = payload_at[last];
            owner_at[p] = owner_at[last];
            slot_of_id[owner_at[last]] = NPOS_W'(p);
            r.moved = 1'b1;
            r.moved_handle = owner_at[last];
          end
        end else if (kind == KIND_WRITE) begin
          payload_at[p] = payload;
        end
      end
      r.live_count = LIVE_W'(count);
      last_status = r.status;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_response(logic [OUT_TDATA_W-1:0] beat);
      table_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual %0h", $time, beat);
        n_errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 64'(want.status), 64'(beat[O_STATUS_LSB +: STATUS_W]));
      compare_field("new_handle", 64'(want.new_handle),
                    64'(beat[O_NEWH_LSB +: HANDLE_W]));
      compare_field("position", 64'(want.position), 64'(beat[O_POS_LSB +: NPOS_W]));
      compare_field("data_out", want.data_out, beat[O_DOUT_LSB +: DATA_W]);
      compare_field("moved", 64'(want.moved), 64'(beat[O_MOVED_LSB]));
      compare_field("moved_handle", 64'(want.moved_handle),
                    64'(beat[O_MOVH_LSB +: HANDLE_W]));
      compare_field("live_count", 64'(want.live_count),
                    64'(beat[O_LIVE_LSB +: LIVE_W]));
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic [KIND_W-1:0]        s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;

  handle_table_tracker tracker;
  int unsigned         n_sent;
  int unsigned         src_idle_pct;
  int unsigned         rcv_stall_pct;
  int unsigned         quiet_cycles;

  dense_handle_table_swap_remove_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_response(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] random_payload();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(kind_e kind, logic [HANDLE_W-1:0] handle,
                           logic [DATA_W-1:0] payload);
    if (n_sent < 450) begin
      src_idle_pct = 14;
      rcv_stall_pct = 73;
    end else if (n_sent < 900) begin
      src_idle_pct = 73;
      rcv_stall_pct = 14;
    end else begin
      src_idle_pct = 0;
      rcv_stall_pct = 0;
    end
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_TDATA_W - HANDLE_W - DATA_W){1'b0}}, payload, handle};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tracker.apply_request(kind, handle, payload);
    n_sent++;
  endtask

  initial begin
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
    int unsigned         r;
    int unsigned         n_random;
    int unsigned         low_mark;
    bit                  growing;
    tracker = new();
    rcv_stall_pct = 73;
    src_idle_pct = 14;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, payload extremes, swap-remove and last-entry remove
    send_item(KIND_READ, 10'd0, '0);
    send_item(KIND_REMOVE, 10'd1023, '1);
    send_item(KIND_ADD, 10'd0, '0);
    send_item(KIND_ADD, 10'd1023, '1);
    send_item(KIND_ADD, 10'd0, 64'hA5A5_5A5A_F00F_0FF0);
    send_item(KIND_ADD, 10'd0, random_payload());
    send_item(KIND_READ, 10'd1, '0);
    send_item(KIND_WRITE, 10'd2, '1);
    send_item(KIND_WRITE, 10'd0, 64'h5555_AAAA_5555_AAAA);
    send_item(KIND_READ, 10'd2, '0);
    send_item(KIND_REMOVE, 10'd0, '0);
    send_item(KIND_REMOVE, 10'd3, '0);
    send_item(KIND_READ, 10'd2, '0);
    send_item(KIND_ADD, 10'd0, '1);
    send_item(KIND_REMOVE, 10'd4, '0);
    send_item(KIND_REMOVE, 10'd0, '0);
    send_item(KIND_WRITE, 10'd3, '1);
    send_item(KIND_READ, 10'd1023, '0);
    send_item(KIND_WRITE, 10'd1023, '1);
    send_item(KIND_REMOVE, 10'd1, '0);
    send_item(KIND_REMOVE, 10'd2, '0);
    send_item(KIND_READ, 10'd2, '0);

    // random: fill to full, drain, refill
    growing = 1'b1;
    low_mark = 0;
    n_random = 0;
    while (n_random < 1280) begin
      if (growing && ((tracker.last_status == ST_FULL && $urandom_range(0, 1) == 0) ||
                      (tracker.id_next >= ID_SPACE && $urandom_range(0, 19) == 0))) begin
        growing = 1'b0;
        low_mark = $urandom_range(0, 12);
      end else if (!growing && tracker.count <= low_mark) begin
        growing = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        kind = kind_e'($urandom_range(0, 3));
        handle = HANDLE_W'($urandom_range(0, ID_SPACE - 1));
      end else begin
        r = $urandom_range(0, 99);
        if (growing) begin
          kind = (r < 78) ? KIND_ADD : (r < 86) ? KIND_READ : (r < 93) ? KIND_WRITE
                                                                       : KIND_REMOVE;
        end else begin
          kind = (r < 18) ? KIND_ADD : (r < 70) ? KIND_REMOVE : (r < 85) ? KIND_READ
                                                                         : KIND_WRITE;
        end
        if (tracker.count == 0) begin
          handle = HANDLE_W'($urandom_range(0, ID_SPACE - 1));
        end else begin
          handle = tracker.pick_live_id();
        end
      end
      send_item(kind, handle, random_payload());
      n_random++;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
